[rtl/core/akr_pkg.sv]
// ----------------------------------------------------------------------------
// akr_pkg
// Shared types, register codes and reset values for the accelerating key
// repeat core.
// ----------------------------------------------------------------------------
package akr_pkg;

   // key bitmap and time widths
   localparam int KEY_WIDTH          = 32;
   localparam int TIME_WIDTH         = 32;
   localparam int KEY_COUNT_DEFAULT  = 32;

   // configuration port
   localparam int CSR_INDEX_WIDTH    = 8;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_DELAY   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_DELAY   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DELAY_STEP  = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHARED_MODE = 8'd3;

   // register reset values
   localparam logic [TIME_WIDTH-1:0] MIN_DELAY_RESET  = 32'd70;
   localparam logic [TIME_WIDTH-1:0] MAX_DELAY_RESET  = 32'd420;
   localparam logic [TIME_WIDTH-1:0] DELAY_STEP_RESET = 32'd70;

   // request commands
   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // repeat timing settings seen by every lane
   typedef struct packed {
      logic [TIME_WIDTH-1:0] min_delay;
      logic [TIME_WIDTH-1:0] max_delay;
      logic [TIME_WIDTH-1:0] delay_step;
   } akr_cfg_type;

   // per-poll control for the timer lanes
   typedef struct packed {
      logic                  restart;
      logic [TIME_WIDTH-1:0] restart_delay;
      logic                  step_en;
      logic [TIME_WIDTH-1:0] now;
   } akr_lane_ctl_type;

   // one result transaction
   typedef struct packed {
      logic [KEY_WIDTH-1:0] pulsed_keys;
      logic [KEY_WIDTH-1:0] held_keys;
   } akr_rsp_type;

endpackage

[rtl/core/akr_intf.sv]
// ----------------------------------------------------------------------------
// akr channel interfaces
// Valid/ready channels for key polls, repeat results and register writes.
// ----------------------------------------------------------------------------

// key poll channel
interface akr_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [akr_pkg::KEY_WIDTH-1:0]   pressed_keys;
   logic [akr_pkg::TIME_WIDTH-1:0]  now;

   modport source (output valid, output cmd, output pressed_keys, output now, input ready);
   modport sink   (input valid, input cmd, input pressed_keys, input now, output ready);
endinterface

// repeat result channel
interface akr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [akr_pkg::KEY_WIDTH-1:0]   pulsed_keys;
   logic [akr_pkg::KEY_WIDTH-1:0]   held_keys;

   modport source (output valid, output pulsed_keys, output held_keys, input ready);
   modport sink   (input valid, input pulsed_keys, input held_keys, output ready);
endinterface

// register write channel
interface akr_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [akr_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [akr_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/accelerating_key_repeat_core.sv]
// ----------------------------------------------------------------------------
// accelerating_key_repeat_core
// Typematic key repeat with acceleration, per-key or shared timer.
// ----------------------------------------------------------------------------
// One poll transaction is taken every clock cycle as long as the two-entry
// result buffer has room; its result is offered on the rsp channel in the
// cycle after acceptance unless older results are still queued. Every key has
// its own timer lane for the elapsed-time compare and delay shrink, a
// further lane serves shared mode, and a merging stage builds the bitmaps.
// Register writes are always taken and, to a known register, restart all
// repeat history; they are to be issued only while no poll is in flight.
module accelerating_key_repeat_core #(
   parameter int KEY_COUNT = akr_pkg::KEY_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   akr_req_if.sink    req,
   akr_rsp_if.source  rsp,
   akr_csr_if.sink    csr
);

   localparam int LANES = (KEY_COUNT < akr_pkg::KEY_WIDTH) ? KEY_COUNT : akr_pkg::KEY_WIDTH;

   logic [akr_pkg::TIME_WIDTH-1:0] min_delay_ff;
   logic [akr_pkg::TIME_WIDTH-1:0] min_delay_in;
   logic [akr_pkg::TIME_WIDTH-1:0] max_delay_ff;
   logic [akr_pkg::TIME_WIDTH-1:0] max_delay_in;
   logic [akr_pkg::TIME_WIDTH-1:0] delay_step_ff;
   logic [akr_pkg::TIME_WIDTH-1:0] delay_step_in;
   logic                           shared_mode_ff;
   logic                           shared_mode_in;
   logic                           csr_write;
   logic                           csr_hit;

   logic [LANES-1:0]               prev_pressed_ff;
   logic [LANES-1:0]               prev_pressed_in;
   logic                           prev_any_ff;
   logic                           prev_any_in;

   logic [LANES-1:0]               held_lanes;
   logic                           any_held;
   logic                           accept;
   logic                           poll;
   logic                           flush;
   logic                           room;
   logic [LANES-1:0]               key_fire;
   logic                           shared_fire;

   akr_pkg::akr_cfg_type           cfg;
   akr_pkg::akr_lane_ctl_type      key_ctl;
   akr_pkg::akr_lane_ctl_type      shared_ctl;

   // register writes
   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;

   always_comb begin
      min_delay_in   = min_delay_ff;
      max_delay_in   = max_delay_ff;
      delay_step_in  = delay_step_ff;
      shared_mode_in = shared_mode_ff;
      csr_hit        = 1'b0;
      if (csr_write) begin
         unique case (csr.index)
            akr_pkg::REG_MIN_DELAY: begin
               min_delay_in = csr.data;
               csr_hit      = 1'b1;
            end
            akr_pkg::REG_MAX_DELAY: begin
               max_delay_in = csr.data;
               csr_hit      = 1'b1;
            end
            akr_pkg::REG_DELAY_STEP: begin
               delay_step_in = csr.data;
               csr_hit       = 1'b1;
            end
            akr_pkg::REG_SHARED_MODE: begin
               shared_mode_in = csr.data[0];
               csr_hit        = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff   <= akr_pkg::MIN_DELAY_RESET;
         max_delay_ff   <= akr_pkg::MAX_DELAY_RESET;
         delay_step_ff  <= akr_pkg::DELAY_STEP_RESET;
         shared_mode_ff <= 1'b0;
      end else begin
         min_delay_ff   <= min_delay_in;
         max_delay_ff   <= max_delay_in;
         delay_step_ff  <= delay_step_in;
         shared_mode_ff <= shared_mode_in;
      end
   end

   // poll decode
   assign req.ready  = room;
   assign accept     = req.valid && req.ready;
   assign flush      = accept && (req.cmd == akr_pkg::CMD_FLUSH);
   assign poll       = accept && (req.cmd == akr_pkg::CMD_POLL);
   assign held_lanes = req.pressed_keys[LANES-1:0];
   assign any_held   = |held_lanes;

   // previous-poll history
   always_comb begin
      prev_pressed_in = prev_pressed_ff;
      prev_any_in     = prev_any_ff;
      if (csr_hit || flush) begin
         prev_pressed_in = '0;
         prev_any_in     = 1'b0;
      end else if (poll) begin
         prev_pressed_in = held_lanes;
         prev_any_in     = any_held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pressed_ff <= '0;
         prev_any_ff     <= 1'b0;
      end else begin
         prev_pressed_ff <= prev_pressed_in;
         prev_any_ff     <= prev_any_in;
      end
   end

   // lane control
   assign cfg.min_delay  = min_delay_ff;
   assign cfg.max_delay  = max_delay_ff;
   assign cfg.delay_step = delay_step_ff;

   assign key_ctl.restart       = csr_hit;
   assign key_ctl.restart_delay = max_delay_in;
   assign key_ctl.step_en       = poll && !shared_mode_ff;
   assign key_ctl.now           = req.now;

   assign shared_ctl.restart       = csr_hit;
   assign shared_ctl.restart_delay = max_delay_in;
   assign shared_ctl.step_en       = poll && shared_mode_ff;
   assign shared_ctl.now           = req.now;

   // per-key timer lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      akr_timer_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .ctl       (key_ctl),
         .held      (held_lanes[g]),
         .prev_held (prev_pressed_ff[g]),
         .fire      (key_fire[g])
      );
   end

   // shared timer lane
   akr_timer_lane u_shared_lane (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctl       (shared_ctl),
      .held      (any_held),
      .prev_held (prev_any_ff),
      .fire      (shared_fire)
   );

   // merge and output buffer
   akr_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .flush       (flush),
      .shared_mode (shared_mode_ff),
      .held        (held_lanes),
      .key_fire    (key_fire),
      .shared_fire (shared_fire),
      .room        (room),
      .rsp         (rsp)
   );

   // a key can only pulse while it is held
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.pulsed_keys & ~rsp.held_keys) == '0))
      else $error("pulsed key not held");

   // any-held history tracks the per-key history
   assert property (@(posedge clock) disable iff (reset)
      prev_any_ff == (|prev_pressed_ff))
      else $error("shared history out of step with key history");

   // a flush clears the history
   assert property (@(posedge clock) disable iff (reset)
      flush |=> (prev_pressed_ff == '0) && !prev_any_ff)
      else $error("flush left key history");

   // a register write restarts the history
   assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (prev_pressed_ff == '0))
      else $error("register write left key history");

endmodule

[rtl/core/akr_timer_lane.sv]
// ----------------------------------------------------------------------------
// akr_timer_lane
// One repeat timer: holds a delay and the time of the last pulse, decides
// whether a held key fires and shortens the delay after each repeat.
// ----------------------------------------------------------------------------
module akr_timer_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  akr_pkg::akr_cfg_type       cfg,
   input  akr_pkg::akr_lane_ctl_type  ctl,
   input  logic                       held,
   input  logic                       prev_held,
   output logic                       fire
);

   logic [akr_pkg::TIME_WIDTH-1:0] delay_ff;
   logic [akr_pkg::TIME_WIDTH-1:0] delay_in;
   logic [akr_pkg::TIME_WIDTH-1:0] last_ff;
   logic [akr_pkg::TIME_WIDTH-1:0] last_in;
   logic [akr_pkg::TIME_WIDTH-1:0] elapsed;
   logic [akr_pkg::TIME_WIDTH-1:0] shrunk;
   logic                           repeating;
   logic                           due;

   // elapsed time wraps modulo 2^32
   assign elapsed   = ctl.now - last_ff;
   assign due       = (elapsed >= delay_ff);
   assign repeating = held && prev_held;

   // shorten the delay, saturating at the minimum
   assign shrunk = ((delay_ff > cfg.min_delay) &&
                    ((delay_ff - cfg.min_delay) > cfg.delay_step)) ?
                   (delay_ff - cfg.delay_step) : cfg.min_delay;

   // fire on a fresh press or on a repeat that is due
   assign fire = repeating ? due : held;

   // next timer state
   always_comb begin
      delay_in = delay_ff;
      last_in  = last_ff;
      if (ctl.restart) begin
         delay_in = ctl.restart_delay;
         last_in  = '0;
      end else if (ctl.step_en) begin
         if (repeating) begin
            if (due) begin
               delay_in = shrunk;
               last_in  = ctl.now;
            end
         end else begin
            delay_in = cfg.max_delay;
            last_in  = ctl.now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= akr_pkg::MAX_DELAY_RESET;
         last_ff  <= '0;
      end else begin
         delay_ff <= delay_in;
         last_ff  <= last_in;
      end
   end

endmodule

[rtl/core/akr_merge.sv]
// ----------------------------------------------------------------------------
// akr_merge
// Combines the per-key and shared timer decisions into the result bitmaps
// and holds them in a two-entry output buffer.
// ----------------------------------------------------------------------------
module akr_merge #(
   parameter int LANES = akr_pkg::KEY_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              flush,
   input  logic              shared_mode,
   input  logic [LANES-1:0]  held,
   input  logic [LANES-1:0]  key_fire,
   input  logic              shared_fire,
   output logic              room,
   akr_rsp_if.source         rsp
);

   logic [akr_pkg::KEY_WIDTH-1:0] held_w;
   logic [akr_pkg::KEY_WIDTH-1:0] fire_w;
   akr_pkg::akr_rsp_type          entry;
   akr_pkg::akr_rsp_type          buf_ff [2];
   logic                          wr_ptr_ff;
   logic                          rd_ptr_ff;
   logic [1:0]                    count_ff;
   logic [1:0]                    count_in;
   logic                          pop;

   // widen lane bits to the full bitmap, absent keys read as zero
   for (genvar g = 0; g < akr_pkg::KEY_WIDTH; g++) begin : g_pad
      if (g < LANES) begin : g_key
         assign held_w[g] = held[g];
         assign fire_w[g] = key_fire[g];
      end else begin : g_none
         assign held_w[g] = 1'b0;
         assign fire_w[g] = 1'b0;
      end
   end

   // pick the shared or per-key decision, or an empty result on a flush
   always_comb begin
      if (flush) begin
         entry.pulsed_keys = '0;
         entry.held_keys   = '0;
      end else if (shared_mode) begin
         entry.pulsed_keys = shared_fire ? held_w : '0;
         entry.held_keys   = held_w;
      end else begin
         entry.pulsed_keys = fire_w & held_w;
         entry.held_keys   = held_w;
      end
   end

   // output buffer control
   assign room      = (count_ff != 2'd2);
   assign rsp.valid = (count_ff != 2'd0);
   assign pop       = rsp.valid && rsp.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= entry;
      end
   end

   assign rsp.pulsed_keys = buf_ff[rd_ptr_ff].pulsed_keys;
   assign rsp.held_keys   = buf_ff[rd_ptr_ff].held_keys;

endmodule
